// ----- src/fir_filter_circular_assert.svh -----
// assertion macros for the fir filter block
`ifndef FIR_FILTER_CIRCULAR_ASSERT_SVH
`define FIR_FILTER_CIRCULAR_ASSERT_SVH

// same-cycle implication, checked outside reset
`define FFC_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("fir filter: same-cycle check failed");

// next-cycle implication, checked outside reset
`define FFC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("fir filter: next-cycle check failed");

`endif

// ----- src/ffc_pkg.sv -----
// shared constants and controller/datapath types for the fir filter
package ffc_pkg;

  localparam int TAPS_DEFAULT = 64;
  localparam int DATA_W       = 16;
  localparam int TAP_IDX_W    = 6;
  localparam int KIND_W       = 2;
  localparam int IN_TDATA_W   = 40;
  localparam int OUT_TDATA_W  = 16;

  localparam logic [KIND_W-1:0] KIND_SAMPLE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_COEF   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd2;

  typedef struct packed {
    logic start;   // sample beat: store it and begin the tap sweep
    logic issue;   // read one tap and one history entry
    logic finish;  // round the sum into the output register
    logic tap_wr;  // coefficient beat
    logic clr;     // clear-history beat
  } ffc_cmd_t;

  typedef struct packed {
    logic last_tap;
    logic pipe_busy;
    logic out_free;
  } ffc_status_t;

endpackage

// ----- src/ffc_ctrl.sv -----
// sequencer for the fir filter: accepts beats and steps the tap sweep
module ffc_ctrl (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  input  logic [ffc_pkg::KIND_W-1:0]  in_kind,
  output logic                        in_ready,
  input  ffc_pkg::ffc_status_t        status,
  output ffc_pkg::ffc_cmd_t           cmd
);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_RUN   = 3'b010,
    ST_FLUSH = 3'b100
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          unique case (in_kind)
            ffc_pkg::KIND_SAMPLE: begin
              cmd.start  = 1'b1;
              state_next = ST_RUN;
            end
            ffc_pkg::KIND_COEF:  cmd.tap_wr = 1'b1;
            ffc_pkg::KIND_CLEAR: cmd.clr    = 1'b1;
            default: ;
          endcase
        end
      end
      ST_RUN: begin
        cmd.issue = 1'b1;
        if (status.last_tap) begin
          state_next = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        // wait for the multiply pipe to drain and the output slot to open
        if (!status.pipe_busy && status.out_free) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

// ----- src/ffc_datapath.sv -----
// fir datapath: history and tap memories, one mac, rounding and output register
module ffc_datapath #(
  parameter int TAPS = ffc_pkg::TAPS_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  ffc_pkg::ffc_cmd_t                   cmd,
  output ffc_pkg::ffc_status_t                status,
  input  logic signed [ffc_pkg::DATA_W-1:0]   sample_in,
  input  logic [ffc_pkg::TAP_IDX_W-1:0]       tap_index,
  input  logic signed [ffc_pkg::DATA_W-1:0]   tap_value,
  input  logic                                block_last,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [ffc_pkg::DATA_W-1:0]   sample_out,
  output logic                                block_last_out
);

  localparam int PTR_W  = $clog2(TAPS);
  localparam int PROD_W = 2 * ffc_pkg::DATA_W;
  localparam int ACC_W  = PROD_W + PTR_W;
  localparam int FRAC   = ffc_pkg::DATA_W - 1;
  localparam logic [PTR_W-1:0] LAST_IDX = PTR_W'(TAPS - 1);
  localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1 << (FRAC - 1));
  localparam logic signed [ACC_W-1:0] SAT_MAX = ACC_W'((1 << FRAC) - 1);
  localparam logic signed [ACC_W-1:0] SAT_MIN = -ACC_W'(1 << FRAC);

  logic signed [ffc_pkg::DATA_W-1:0] hist_mem [TAPS];
  logic signed [ffc_pkg::DATA_W-1:0] tap_mem  [TAPS];
  logic [TAPS-1:0]                   hist_ok;

  logic [PTR_W-1:0] wp;
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W-1:0] tap_k;
  logic             last_flag;

  logic                              s1_v;
  logic signed [ffc_pkg::DATA_W-1:0] tap_rd;
  logic signed [ffc_pkg::DATA_W-1:0] hist_rd;
  logic                              hist_rd_ok;
  logic signed [ffc_pkg::DATA_W-1:0] hist_eff;
  logic                              s2_v;
  logic signed [PROD_W-1:0]          prod;
  logic signed [ACC_W-1:0]           acc;

  logic signed [ACC_W-1:0]           rnd_sum;
  logic signed [ACC_W-1:0]           rnd_shift;
  logic signed [ffc_pkg::DATA_W-1:0] sat_val;
  logic                              tap_in_range;

  assign tap_in_range = 32'(tap_index) < TAPS;

  // memory writes and registered reads
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      hist_mem[wp] <= sample_in;
    end
    if (cmd.tap_wr && tap_in_range) begin
      tap_mem[tap_index[PTR_W-1:0]] <= tap_value;
    end
    if (cmd.issue) begin
      tap_rd     <= tap_mem[tap_k];
      hist_rd    <= hist_mem[rd_ptr];
      hist_rd_ok <= hist_ok[rd_ptr];
    end
  end

  // history entries not written since the last clear read as zero
  always_ff @(posedge clk) begin
    if (rst || cmd.clr) begin
      hist_ok <= '0;
      wp      <= '0;
    end else if (cmd.start) begin
      hist_ok[wp] <= 1'b1;
      wp          <= (wp == LAST_IDX) ? '0 : wp + 1'b1;
    end
  end

  // tap sweep: k counts up, read pointer walks back from the newest sample
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      rd_ptr    <= wp;
      tap_k     <= '0;
      last_flag <= block_last;
    end else if (cmd.issue) begin
      rd_ptr <= (rd_ptr == '0) ? LAST_IDX : rd_ptr - 1'b1;
      tap_k  <= tap_k + 1'b1;
    end
  end

  assign hist_eff = hist_rd_ok ? hist_rd : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
      s2_v <= 1'b0;
    end else begin
      s1_v <= cmd.issue;
      s2_v <= s1_v;
    end
  end

  always_ff @(posedge clk) begin
    prod <= tap_rd * hist_eff;
    if (cmd.start) begin
      acc <= '0;
    end else if (s2_v) begin
      acc <= acc + ACC_W'(prod);
    end
  end

  // round half up to q1.15, then saturate
  assign rnd_sum   = acc + ROUND_HALF;
  assign rnd_shift = rnd_sum >>> FRAC;

  always_comb begin
    priority if (rnd_shift > SAT_MAX) begin
      sat_val = SAT_MAX[ffc_pkg::DATA_W-1:0];
    end else if (rnd_shift < SAT_MIN) begin
      sat_val = SAT_MIN[ffc_pkg::DATA_W-1:0];
    end else begin
      sat_val = rnd_shift[ffc_pkg::DATA_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      sample_out     <= sat_val;
      block_last_out <= last_flag;
    end
  end

  assign status.last_tap  = (tap_k == LAST_IDX);
  assign status.pipe_busy = s1_v || s2_v;
  assign status.out_free  = !out_valid || out_ready;

endmodule

// ----- src/fir_filter_circular.sv -----
// Direct-form FIR filter with a circular history of TAPS signed Q1.15 samples and a
// loadable coefficient store. A sample beat (tuser 0) is stored in the history, then a
// single multiply-accumulate unit walks all TAPS coefficients against the history, one
// tap per cycle, reading the coefficient and history memories through one read port each;
// the exact sum is rounded half up to Q1.15 and saturated. A sample beat keeps the input
// closed from acceptance through the TAPS tap reads, the drain of the multiply pipe and
// the rounding into the output register, until the controller is back in idle. The
// result sits in that register, so the next beat is accepted while it waits; a later
// sweep holds in its flush state until the register is free again. Coefficient beats
// (tuser 1) and clear beats (tuser 2) are taken in idle and give no
// output; tuser 3 is ignored. Coefficients must be loaded before use and are not
// cleared by reset or by a clear beat; the history reads as zero after reset or clear.
module fir_filter_circular #(
  parameter int TAPS = ffc_pkg::TAPS_DEFAULT
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // sample_in [15:0], tap_index [21:16], tap_value [37:22], zero [39:38]
  input  logic [ffc_pkg::IN_TDATA_W-1:0]       s_axis_tdata,
  // kind [1:0]
  input  logic [ffc_pkg::KIND_W-1:0]           s_axis_tuser,
  input  logic                                 s_axis_tlast,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // sample_out [15:0]
  output logic [ffc_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
  output logic                                 m_axis_tlast
);

  ffc_pkg::ffc_cmd_t    cmd;
  ffc_pkg::ffc_status_t status;
  logic signed [ffc_pkg::DATA_W-1:0] sample_out;

  ffc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_kind  (s_axis_tuser),
    .in_ready (s_axis_tready),
    .status   (status),
    .cmd      (cmd)
  );

  ffc_datapath #(
    .TAPS (TAPS)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .sample_in      (s_axis_tdata[15:0]),
    .tap_index      (s_axis_tdata[21:16]),
    .tap_value      (s_axis_tdata[37:22]),
    .block_last     (s_axis_tlast),
    .out_valid      (m_axis_tvalid),
    .out_ready      (m_axis_tready),
    .sample_out     (sample_out),
    .block_last_out (m_axis_tlast)
  );

  assign m_axis_tdata = sample_out;

`include "fir_filter_circular_assert.svh"

  // the input side only opens when no sweep is in the multiply pipe
  `FFC_ASSERT_NOW(a_ready_idle, clk, rst, s_axis_tready, !status.pipe_busy && !cmd.issue)
  // a sample beat closes the input until its result is formed
  `FFC_ASSERT_NEXT(a_sample_busy, clk, rst, s_axis_tvalid && s_axis_tready && s_axis_tuser == ffc_pkg::KIND_SAMPLE, !s_axis_tready)
  // a finished sum is always presented on the next cycle
  `FFC_ASSERT_NEXT(a_finish_out, clk, rst, cmd.finish, m_axis_tvalid)

endmodule
